@@ hdl/ssf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssf_pkg
// shared types and constants for the servo supervisor fault fsm
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

  localparam int SERVO_CHANNELS = 22;
  localparam int COUNT_BITS     = 16;

  localparam int ONLINE_W   = 22;
  localparam int CHANGE_W   = 16;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ONLINE_W-1:0] CHAN_MASK = (SERVO_CHANNELS >= ONLINE_W) ?
    {ONLINE_W{1'b1}} : ONLINE_W'((64'd1 << SERVO_CHANNELS) - 64'd1);
  localparam logic CHAN_FIT = (SERVO_CHANNELS <= ONLINE_W);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAN_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_ALL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_MASK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_J16_ENABLE    = 3'd5;

  // event codes
  localparam logic [2:0] EV_START      = 3'd0;
  localparam logic [2:0] EV_STOP       = 3'd1;
  localparam logic [2:0] EV_RESET      = 3'd2;
  localparam logic [2:0] EV_CALIBRATE  = 3'd3;
  localparam logic [2:0] EV_CALIB_DONE = 3'd4;
  localparam logic [2:0] EV_CALIB_FAIL = 3'd5;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // modes
  localparam logic [2:0] M_BOOT  = 3'd0;
  localparam logic [2:0] M_IDLE  = 3'd1;
  localparam logic [2:0] M_RUN   = 3'd2;
  localparam logic [2:0] M_STOP  = 3'd3;
  localparam logic [2:0] M_HOLD  = 3'd4;
  localparam logic [2:0] M_CIDLE = 3'd5;
  localparam logic [2:0] M_COK   = 3'd6;
  localparam logic [2:0] M_CFAIL = 3'd7;

  // target owners
  localparam logic [1:0] OWN_NONE  = 2'd0;
  localparam logic [1:0] OWN_CTRL  = 2'd1;
  localparam logic [1:0] OWN_CALIB = 2'd2;

  // calibration status
  localparam logic [1:0] CAL_IDLE = 2'd0;
  localparam logic [1:0] CAL_OK   = 2'd1;
  localparam logic [1:0] CAL_FAIL = 2'd2;

  // fault bit positions
  localparam int F_CAN   = 0;
  localparam int F_SERVO = 1;
  localparam int F_J16   = 2;
  localparam int F_OVL   = 3;
  localparam int F_REL   = 4;

  localparam logic [7:0] OFFLINE_MAX = 8'd255;

  typedef struct packed {
    logic [15:0]         can_timeout_ms;
    logic [15:0]         servo_timeout_ms;
    logic [7:0]          offline_fault_ticks;
    logic                require_all_servos;
    logic [ONLINE_W-1:0] required_servo_mask;
    logic                joint16_check_enable;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [2:0]          event_code;
    logic [31:0]         now_ms;
    logic                can_ok;
    logic [31:0]         can_stamp_ms;
    logic                servo_present;
    logic [31:0]         servo_stamp_ms;
    logic [ONLINE_W-1:0] servo_online;
    logic                joint16_fault;
    logic                overload_any;
    logic                release_guard_any;
    logic                direct_mode;
  } item_t;

  typedef struct packed {
    logic [2:0]          system_mode;
    logic                control_on;
    logic [1:0]          target_owner;
    logic [4:0]          fault_flags;
    logic [CHANGE_W-1:0] change_count;
    logic                clear_queue;
    logic                hold_pulse;
    logic                fault_reset;
    logic                command_clear;
    logic                force_joint;
    logic [1:0]          calib_status;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/ssf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ssf_cfg_regs
// configuration register file with reset defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ssf_pkg::cfg_t                       cfg
);
  import ssf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.can_timeout_ms       <= 16'd300;
      cfg_r.servo_timeout_ms     <= 16'd500;
      cfg_r.offline_fault_ticks  <= 8'd30;
      cfg_r.require_all_servos   <= 1'b0;
      cfg_r.required_servo_mask  <= ONLINE_W'(3);
      cfg_r.joint16_check_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAN_TIMEOUT:   cfg_r.can_timeout_ms       <= cfg_wdata[15:0];
        CFG_SERVO_TIMEOUT: cfg_r.servo_timeout_ms     <= cfg_wdata[15:0];
        CFG_OFFLINE_TICKS: cfg_r.offline_fault_ticks  <= cfg_wdata[7:0];
        CFG_REQUIRE_ALL:   cfg_r.require_all_servos   <= cfg_wdata[0];
        CFG_REQ_MASK:      cfg_r.required_servo_mask  <= cfg_wdata[ONLINE_W-1:0];
        CFG_J16_ENABLE:    cfg_r.joint16_check_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hdl/ssf_in_stage.sv @@
// ----------------------------------------------------------------------------
// ssf_in_stage
// input register: captures one transaction and holds it until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_in_stage (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ssf_pkg::item_t in_item,
  input  wire logic     core_take,
  output logic          s1_valid,
  output ssf_pkg::item_t s1_item
);
  import ssf_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;
  logic  accept;

  assign in_stall = s1_valid_r && !core_take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (core_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

@@ hdl/ssf_core.sv @@
// ----------------------------------------------------------------------------
// ssf_core
// supervisor state, event and tick next-state logic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ssf_pkg::cfg_t   cfg,
  input  wire logic       s1_valid,
  input  wire ssf_pkg::item_t  s1_item,
  output logic            core_take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output ssf_pkg::result_t out_res
);
  import ssf_pkg::*;

  logic [2:0]            mode_r, mode_nxt;
  logic                  enable_r, enable_nxt;
  logic [1:0]            owner_r, owner_nxt;
  logic [4:0]            fault_r, fault_nxt;
  logic [7:0]            offline_r, offline_nxt;
  logic [COUNT_BITS-1:0] change_r, change_nxt;
  logic [1:0]            calib_r, calib_nxt;
  logic                  clr, hold, frst, cclr, fj;

  logic                  out_valid_r;
  result_t               out_res_r;

  logic [31:0]           can_age, servo_age;
  logic                  offline;
  logic [4:0]            faults;
  logic                  to_hold;

  assign core_take = s1_valid && (!out_valid_r || !out_stall);

  always_comb begin
    can_age   = s1_item.now_ms - s1_item.can_stamp_ms;
    servo_age = s1_item.now_ms - s1_item.servo_stamp_ms;

    if (s1_item.servo_present && (servo_age <= {16'd0, cfg.servo_timeout_ms})) begin
      if (cfg.require_all_servos) begin
        offline = !CHAN_FIT || ((s1_item.servo_online & CHAN_MASK) != CHAN_MASK);
      end else begin
        offline = (|(cfg.required_servo_mask & ~CHAN_MASK)) ||
                  ((s1_item.servo_online & cfg.required_servo_mask) !=
                   cfg.required_servo_mask);
      end
    end else begin
      offline = 1'b1;
    end

    if (offline) begin
      offline_nxt = (offline_r == OFFLINE_MAX) ? OFFLINE_MAX : offline_r + 8'd1;
    end else begin
      offline_nxt = 8'd0;
    end

    faults          = 5'd0;
    faults[F_CAN]   = !s1_item.can_ok || (can_age > {16'd0, cfg.can_timeout_ms});
    faults[F_SERVO] = (offline_nxt >= cfg.offline_fault_ticks);
    faults[F_J16]   = cfg.joint16_check_enable && s1_item.joint16_fault;
    faults[F_OVL]   = s1_item.overload_any;
    faults[F_REL]   = s1_item.release_guard_any;

    if (faults == 5'd0) begin
      to_hold = 1'b0;
    end else if (s1_item.direct_mode) begin
      to_hold = faults[F_OVL] || faults[F_REL];
    end else begin
      to_hold = 1'b1;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    enable_nxt = enable_r;
    owner_nxt  = owner_r;
    fault_nxt  = fault_r;
    calib_nxt  = calib_r;
    clr        = 1'b0;
    hold       = 1'b0;
    frst       = 1'b0;
    cclr       = 1'b0;
    fj         = 1'b0;

    if (s1_item.kind == KIND_EVENT) begin
      unique case (s1_item.event_code)
        EV_START: begin
          clr = 1'b1; cclr = 1'b1; frst = 1'b1;
          owner_nxt = OWN_CTRL; enable_nxt = 1'b1; mode_nxt = M_RUN;
        end
        EV_STOP: begin
          clr = 1'b1; hold = 1'b1;
          owner_nxt = OWN_NONE; enable_nxt = 1'b0; mode_nxt = M_STOP;
        end
        EV_RESET: begin
          cclr = 1'b1; clr = 1'b1; hold = 1'b1; frst = 1'b1;
          enable_nxt = 1'b0; owner_nxt = OWN_NONE; fault_nxt = 5'd0;
          mode_nxt = M_IDLE;
        end
        EV_CALIBRATE: begin
          clr = 1'b1; fj = 1'b1;
          owner_nxt = OWN_CALIB; enable_nxt = 1'b0; calib_nxt = CAL_IDLE;
          mode_nxt = M_CIDLE;
        end
        EV_CALIB_DONE: begin
          enable_nxt = 1'b0; owner_nxt = OWN_CALIB; calib_nxt = CAL_OK;
          mode_nxt = M_COK;
        end
        EV_CALIB_FAIL: begin
          enable_nxt = 1'b0; owner_nxt = OWN_CALIB; calib_nxt = CAL_FAIL;
          mode_nxt = M_CFAIL;
        end
        default: ;
      endcase
    end else begin
      fault_nxt = faults;
      if (faults[F_CAN] && enable_r) begin
        enable_nxt = 1'b0;
        owner_nxt  = OWN_NONE;
        clr        = 1'b1;
        hold       = 1'b1;
        mode_nxt   = M_HOLD;
      end else if (enable_r) begin
        mode_nxt = to_hold ? M_HOLD : M_RUN;
      end else if (mode_r == M_BOOT) begin
        mode_nxt = M_IDLE;
      end
    end

    change_nxt = change_r + COUNT_BITS'(mode_nxt != mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_BOOT;
      enable_r  <= 1'b0;
      owner_r   <= OWN_NONE;
      fault_r   <= 5'd0;
      offline_r <= 8'd0;
      change_r  <= '0;
      calib_r   <= CAL_IDLE;
    end else if (core_take) begin
      mode_r   <= mode_nxt;
      enable_r <= enable_nxt;
      owner_r  <= owner_nxt;
      fault_r  <= fault_nxt;
      change_r <= change_nxt;
      calib_r  <= calib_nxt;
      if (s1_item.kind == KIND_TICK) begin
        offline_r <= offline_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      out_res_r.system_mode   <= mode_nxt;
      out_res_r.control_on    <= enable_nxt;
      out_res_r.target_owner  <= owner_nxt;
      out_res_r.fault_flags   <= fault_nxt;
      out_res_r.change_count  <= CHANGE_W'(change_nxt);
      out_res_r.clear_queue   <= clr;
      out_res_r.hold_pulse    <= hold;
      out_res_r.fault_reset   <= frst;
      out_res_r.command_clear <= cclr;
      out_res_r.force_joint   <= fj;
      out_res_r.calib_status  <= calib_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_enable_owner: assert property (@(posedge clk) disable iff (!rst_n)
    enable_r |-> owner_r == OWN_CTRL)
    else $error("control enabled without control ownership");

  a_change_only_on_mode: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == $past(mode_r) |-> change_r == $past(change_r))
    else $error("change count moved without a mode change");

  a_hold_disables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.hold_pulse |-> !out_res_r.control_on)
    else $error("hold pulse with control still on");

  a_fault_reset_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fault_reset |->
      (out_res_r.system_mode == M_RUN || out_res_r.system_mode == M_IDLE))
    else $error("fault reset pulse outside start or reset");

endmodule

`default_nettype wire

@@ hdl/servo_supervisor_fault_fsm.sv @@
// ----------------------------------------------------------------------------
// servo_supervisor_fault_fsm
// servo controller supervisor: command events and periodic fault ticks
// ----------------------------------------------------------------------------
// Each input transaction (an event or a tick) yields exactly one result
// transaction. A transaction passes an input register and then the
// supervisor logic into a result register: the input register loads at the
// accepting edge and the result register at the edge on which the core takes
// the transaction, which a stalled output holds off. One transaction is
// accepted every cycle while the output is not stalled; the supervisor state
// is updated between the two registers, so nothing else limits that rate.
// A stalled result holds the input register and so stalls the input.
// Configuration writes take effect on the next edge and should be made
// while no transaction is in flight.
`default_nettype none

module servo_supervisor_fault_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_kind,
  input  wire logic [2:0]                     in_event_code,
  input  wire logic [31:0]                    in_now_ms,
  input  wire logic                           in_can_ok,
  input  wire logic [31:0]                    in_can_stamp_ms,
  input  wire logic                           in_servo_present,
  input  wire logic [31:0]                    in_servo_stamp_ms,
  input  wire logic [ssf_pkg::ONLINE_W-1:0]   in_servo_online,
  input  wire logic                           in_joint16_fault,
  input  wire logic                           in_overload_any,
  input  wire logic                           in_release_guard_any,
  input  wire logic                           in_direct_mode,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_system_mode,
  output logic                                out_control_on,
  output logic [1:0]                          out_target_owner,
  output logic [4:0]                          out_fault_flags,
  output logic [ssf_pkg::CHANGE_W-1:0]        out_change_count,
  output logic                                out_clear_queue,
  output logic                                out_hold_pulse,
  output logic                                out_fault_reset,
  output logic                                out_command_clear,
  output logic                                out_force_joint,
  output logic [1:0]                          out_calib_status
);
  import ssf_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    core_take;
  result_t res;

  assign in_item.kind              = in_kind;
  assign in_item.event_code        = in_event_code;
  assign in_item.now_ms            = in_now_ms;
  assign in_item.can_ok            = in_can_ok;
  assign in_item.can_stamp_ms      = in_can_stamp_ms;
  assign in_item.servo_present     = in_servo_present;
  assign in_item.servo_stamp_ms    = in_servo_stamp_ms;
  assign in_item.servo_online      = in_servo_online;
  assign in_item.joint16_fault     = in_joint16_fault;
  assign in_item.overload_any      = in_overload_any;
  assign in_item.release_guard_any = in_release_guard_any;
  assign in_item.direct_mode       = in_direct_mode;

  ssf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .core_take (core_take),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  ssf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .core_take (core_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_system_mode   = res.system_mode;
  assign out_control_on    = res.control_on;
  assign out_target_owner  = res.target_owner;
  assign out_fault_flags   = res.fault_flags;
  assign out_change_count  = res.change_count;
  assign out_clear_queue   = res.clear_queue;
  assign out_hold_pulse    = res.hold_pulse;
  assign out_fault_reset   = res.fault_reset;
  assign out_command_clear = res.command_clear;
  assign out_force_joint   = res.force_joint;
  assign out_calib_status  = res.calib_status;

endmodule

`default_nettype wire
